// ----- src/mcfl_pkg.sv -----
// mcfl_pkg: shared types and constants of the mhd cfl time step block
// cell and result payloads, configuration struct, register indexes
// no dependencies
`default_nettype none
package mcfl_pkg;

  localparam int unsigned AddrWidth = 4;

  localparam logic [1:0] RegGamma   = 2'd0;
  localparam logic [1:0] RegWidth   = 2'd1;
  localparam logic [1:0] RegOffset  = 2'd2;
  localparam logic [1:0] RegCourant = 2'd3;

  localparam logic [17:0] GammaReset   = 18'd109227;
  localparam logic [30:0] WidthReset   = 31'd655;
  localparam logic [15:0] OffsetReset  = 16'd1;
  localparam logic [16:0] CourantReset = 17'd45875;

  localparam logic [17:0] OneQ16   = 18'd65536;
  localparam logic [63:0] SqCap    = 64'h0000_8000_0000_0000;
  localparam logic [63:0] SpeedCap = 64'h0000_7FFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] density;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] momentum_z;
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
    logic signed [31:0] total_energy;
    logic               last_cell;
  } cell_t;

  typedef struct packed {
    logic [31:0] time_step;
    logic        bad_cell;
  } result_t;

  typedef struct packed {
    logic [17:0] gamma_ratio;
    logic [30:0] cell_width;
    logic [15:0] small_offset;
    logic [16:0] courant_number;
  } cfg_t;

  // queue entry: cell plus front classification
  typedef struct packed {
    cell_t data;
    logic  no_mass;
  } qent_t;

endpackage
`default_nettype wire

// ----- src/mcfl_front.sv -----
// mcfl_front: accepts cell beats, flags nonpositive density, two-entry queue
// depends on mcfl_pkg
`default_nettype none
module mcfl_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire mcfl_pkg::cell_t in_data_i,
  input  wire logic           pop_i,
  output logic                q_valid_o,
  output mcfl_pkg::qent_t     q_data_o
);
  import mcfl_pkg::*;

  qent_t      ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  qent_t      ent_in;

  // classify on entry
  always_comb begin
    ent_in.data    = in_data_i;
    ent_in.no_mass = in_data_i.density[31] | (in_data_i.density == 32'sd0);
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i & ~in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = pop_i & q_valid_o;
  assign q_data_o   = ent_q[rp_q];

  // queue pointers and storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= ent_in;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 && !push) |=> cnt_q == 2'd0) else $error("queue underflow");
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("queue lost entry");

endmodule
`default_nettype wire

// ----- src/mcfl_div.sv -----
// mcfl_div: 64 by 64 bit restoring divider, one quotient bit per cycle
// depends on nothing
`default_nettype none
module mcfl_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [63:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [63:0]      quot_o
);

  logic [63:0] quo_q, dvs_q;
  logic [64:0] rem_q, rem_sh;
  logic [65:0] diff;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q, ge;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q[63:0], quo_q[63]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    ge     = ~diff[65];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= ge ? diff[64:0] : rem_sh;
        quo_q <= {quo_q[62:0], ge};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without work");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");

endmodule
`default_nettype wire

// ----- src/mcfl_back.sv -----
// mcfl_back: sequencer computing the fast speed bound, running minimum and step
// depends on mcfl_pkg and mcfl_div
`default_nettype none
module mcfl_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mcfl_pkg::cfg_t   cfg_i,
  input  wire logic             q_valid_i,
  input  wire mcfl_pkg::qent_t  q_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output mcfl_pkg::result_t     out_data_o
);
  import mcfl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_DUX, S_DKIN, S_INT, S_PM, S_GM, S_GW, S_DCS, S_DCA,
    S_ROOT, S_SPD, S_RATE, S_CAND, S_UPD, S_OM, S_FIN
  } state_e;

  function automatic logic [31:0] absval(logic signed [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  state_e       st_q;
  logic [30:0]  rho_q;
  logic [5:0][31:0] mag_q;
  logic [31:0]  e_q;
  logic         last_q, bad_q;
  logic [63:0]  ksum_q, bsum_q, kin_q, sx_q, sres_q, sbit_q, den_q;
  logic [47:0]  ux_q, cs_q, speed_q;
  logic [30:0]  int_q;
  logic [32:0]  p_q;
  logic [31:0]  cand_q, min_q;
  logic         seen_q, dgo_q, out_valid_q;
  logic [2:0]   sq_cnt_q;
  logic [4:0]   it_cnt_q;
  result_t      out_q;
  logic [65:0]  mul_q;

  logic [32:0]  mul_a, mul_b;
  logic [63:0]  dv_dividend, dv_divisor, dv_quot;
  logic         dv_start, dv_busy, dv_done, div_state;
  logic [17:0]  gm1;
  logic [30:0]  dx;
  logic [63:0]  loss, root_t, quot_cap;
  logic [48:0]  s2_sum, spd_sum;
  logic [47:0]  s2;
  logic [2:0]   sq_idx;

  // derived configuration
  assign gm1 = (cfg_i.gamma_ratio > OneQ16) ? (cfg_i.gamma_ratio - OneQ16) : 18'd0;
  assign dx  = (cfg_i.cell_width != 31'd0) ? cfg_i.cell_width : 31'd1;

  // shared multiplier operand select
  assign sq_idx = (sq_cnt_q < 3'd6) ? sq_cnt_q : 3'd0;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      S_SQ: begin
        mul_a = {1'b0, mag_q[sq_idx]};
        mul_b = {1'b0, mag_q[sq_idx]};
      end
      S_PM: begin
        mul_a = {15'd0, gm1};
        mul_b = {2'd0, int_q};
      end
      S_GW, S_DCS: begin
        mul_a = {15'd0, cfg_i.gamma_ratio};
        mul_b = p_q;
      end
      S_OM, S_FIN: begin
        mul_a = {1'b0, min_q};
        mul_b = {16'd0, cfg_i.courant_number};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // divider operand select
  always_comb begin
    div_state   = 1'b1;
    dv_dividend = '0;
    dv_divisor  = 64'd1;
    unique case (st_q)
      S_DUX: begin
        dv_dividend = {16'd0, mag_q[0], 16'd0};
        dv_divisor  = {33'd0, rho_q};
      end
      S_DKIN: begin
        dv_dividend = ksum_q;
        dv_divisor  = {32'd0, rho_q, 1'b0};
      end
      S_DCS: begin
        dv_dividend = mul_q[63:0];
        dv_divisor  = {33'd0, rho_q};
      end
      S_DCA: begin
        dv_dividend = bsum_q;
        dv_divisor  = {33'd0, rho_q};
      end
      S_RATE: begin
        dv_dividend = {speed_q, 16'd0};
        dv_divisor  = {33'd0, dx};
      end
      S_CAND: begin
        dv_dividend = 64'h0000_0100_0000_0000;
        dv_divisor  = den_q;
      end
      default: div_state = 1'b0;
    endcase
  end

  assign dv_start = div_state & ~dgo_q & ~((st_q == S_CAND) && (den_q == 64'd0));

  mcfl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_dividend),
    .divisor_i  (dv_divisor),
    .busy_o     (dv_busy),
    .done_o     (dv_done),
    .quot_o     (dv_quot)
  );

  // step arithmetic
  always_comb begin
    loss     = kin_q + {17'd0, bsum_q[63:17]};
    root_t   = sres_q + sbit_q;
    quot_cap = (dv_quot > SqCap) ? SqCap : dv_quot;
    s2_sum   = {1'b0, cs_q} + {1'b0, quot_cap[47:0]};
    s2       = (s2_sum > {1'b0, SqCap[47:0]}) ? SqCap[47:0] : s2_sum[47:0];
    spd_sum  = {1'b0, ux_q} + {17'd0, sres_q[31:0]};
  end

  assign pop_o = (st_q == S_IDLE) & q_valid_i;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      min_q       <= '1;
      seen_q      <= 1'b0;
      dgo_q       <= 1'b0;
      sq_cnt_q    <= '0;
      it_cnt_q    <= '0;
      rho_q <= '0; mag_q <= '0; e_q <= '0; last_q <= 1'b0; bad_q <= 1'b0;
      ksum_q <= '0; bsum_q <= '0; kin_q <= '0; sx_q <= '0; sres_q <= '0;
      sbit_q <= '0; den_q <= '0; ux_q <= '0; cs_q <= '0; speed_q <= '0;
      int_q <= '0; p_q <= '0; cand_q <= '0;
    end else begin
      // the end of sweep state loads the next beat itself
      if (out_valid_q && !out_stall_i && st_q != S_FIN) out_valid_q <= 1'b0;
      if (dv_start) dgo_q <= 1'b1;
      else if (dv_done) dgo_q <= 1'b0;

      unique case (st_q)
        S_IDLE: begin
          if (q_valid_i) begin
            rho_q    <= q_data_i.data.density[30:0];
            mag_q[0] <= absval(q_data_i.data.momentum_x);
            mag_q[1] <= absval(q_data_i.data.momentum_y);
            mag_q[2] <= absval(q_data_i.data.momentum_z);
            mag_q[3] <= absval(q_data_i.data.field_x);
            mag_q[4] <= absval(q_data_i.data.field_y);
            mag_q[5] <= absval(q_data_i.data.field_z);
            e_q      <= q_data_i.data.total_energy;
            last_q   <= q_data_i.data.last_cell;
            bad_q    <= q_data_i.no_mass;
            ksum_q   <= '0;
            bsum_q   <= '0;
            sq_cnt_q <= '0;
            speed_q  <= '0;
            st_q     <= q_data_i.no_mass ? S_RATE : S_SQ;
          end
        end
        S_SQ: begin
          // each square arrives registered, in the cycle after its operand is selected
          sq_cnt_q <= sq_cnt_q + 3'd1;
          if (sq_cnt_q != 3'd0) begin
            if (sq_cnt_q <= 3'd3) ksum_q <= ksum_q + mul_q[63:0];
            else bsum_q <= bsum_q + mul_q[63:0];
          end
          if (sq_cnt_q == 3'd6) st_q <= S_DUX;
        end
        S_DUX: if (dv_done) begin
          ux_q <= dv_quot[47:0];
          st_q <= S_DKIN;
        end
        S_DKIN: if (dv_done) begin
          kin_q <= dv_quot;
          st_q  <= S_INT;
        end
        S_INT: begin
          // internal energy, negative clamps to zero and marks the cell bad
          if (e_q[31] || (loss > {32'd0, e_q})) begin
            bad_q <= 1'b1;
            int_q <= '0;
          end else begin
            int_q <= e_q[30:0] - loss[30:0];
          end
          st_q <= S_PM;
        end
        S_PM: st_q <= S_GM;
        S_GM: begin
          p_q  <= mul_q[48:16];
          st_q <= S_GW;
        end
        S_GW: st_q <= S_DCS;
        S_DCS: if (dv_done) begin
          cs_q <= quot_cap[47:0];
          st_q <= S_DCA;
        end
        S_DCA: if (dv_done) begin
          sx_q     <= {s2, 16'd0};
          sres_q   <= '0;
          sbit_q   <= 64'h4000_0000_0000_0000;
          it_cnt_q <= '0;
          st_q     <= S_ROOT;
        end
        S_ROOT: begin
          // one result bit and two radicand bits per step
          if (sx_q >= root_t) begin
            sx_q   <= sx_q - root_t;
            sres_q <= (sres_q >> 1) + sbit_q;
          end else begin
            sres_q <= sres_q >> 1;
          end
          sbit_q   <= sbit_q >> 2;
          it_cnt_q <= it_cnt_q + 5'd1;
          if (it_cnt_q == 5'd31) st_q <= S_SPD;
        end
        S_SPD: begin
          speed_q <= (spd_sum > {1'b0, SpeedCap[47:0]}) ? SpeedCap[47:0] : spd_sum[47:0];
          st_q    <= S_RATE;
        end
        S_RATE: if (dv_done) begin
          den_q <= dv_quot + {48'd0, cfg_i.small_offset};
          st_q  <= S_CAND;
        end
        S_CAND: begin
          if (!dgo_q && den_q == 64'd0) begin
            cand_q <= '1;
            st_q   <= S_UPD;
          end else if (dv_done) begin
            cand_q <= (dv_quot[63:32] != 32'd0) ? 32'hFFFF_FFFF : dv_quot[31:0];
            st_q   <= S_UPD;
          end
        end
        S_UPD: begin
          if (cand_q < min_q) min_q <= cand_q;
          if (bad_q) seen_q <= 1'b1;
          st_q <= last_q ? S_OM : S_IDLE;
        end
        S_OM: st_q <= S_FIN;
        S_FIN: begin
          // hold until the output register is free
          if (!(out_valid_q && out_stall_i)) begin
            out_valid_q     <= 1'b1;
            out_q.time_step <= (mul_q[65:48] != 18'd0) ? 32'hFFFF_FFFF : mul_q[47:16];
            out_q.bad_cell  <= seen_q;
            min_q           <= '1;
            seen_q          <= 1'b0;
            st_q            <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_start |-> !dv_busy) else $error("divider started while busy");
  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FIN && out_valid_q && out_stall_i) |=> st_q == S_FIN)
    else $error("result dropped under stall");
  a_rise_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q) == S_FIN) else $error("stray result");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> st_q == S_IDLE) else $error("pop outside idle");

endmodule
`default_nettype wire

// ----- src/mhd_cfl_time_step.sv -----
// mhd_cfl_time_step: top level with apb register bank, front queue and back
// depends on mcfl_pkg, mcfl_front, mcfl_back
//
// channel | direction | handshake          | beat
// in      | input     | in_valid_i/stall_o | one cell of conserved variables
// out     | output    | out_valid_o/stall_i| time step and bad flag at sweep end
// cfg     | input     | apb psel/penable   | one 32 bit register write or read
//
// a cell with positive density runs six divisions in the back sequencer on its one shared
// 64 bit divider, plus a 32 step root and the other states between them.
// a cell with nonpositive density skips to the rate division; a zero denominator skips the last.
// the front queue holds two cells, so input beats flow while the back works, until it fills.
// a last cell then passes through the scaled output states, held while the result is stalled.
// reset clears the running minimum to all ones and the bad flag, no sweep.
`default_nettype none
module mhd_cfl_time_step (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire mcfl_pkg::cell_t                 in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output mcfl_pkg::result_t                    out_data_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mcfl_pkg::AddrWidth-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import mcfl_pkg::*;

  cfg_t  cfg_q;
  logic  wr_en;
  logic  q_valid, pop;
  qent_t q_data;

  // register bank
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gamma_ratio    <= GammaReset;
      cfg_q.cell_width     <= WidthReset;
      cfg_q.small_offset   <= OffsetReset;
      cfg_q.courant_number <= CourantReset;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        RegGamma:   cfg_q.gamma_ratio    <= pwdata[17:0];
        RegWidth:   cfg_q.cell_width     <= pwdata[30:0];
        RegOffset:  cfg_q.small_offset   <= pwdata[15:0];
        RegCourant: cfg_q.courant_number <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[3:2])
      RegGamma:   prdata = {14'd0, cfg_q.gamma_ratio};
      RegWidth:   prdata = {1'b0, cfg_q.cell_width};
      RegOffset:  prdata = {16'd0, cfg_q.small_offset};
      RegCourant: prdata = {15'd0, cfg_q.courant_number};
      default:    prdata = '0;
    endcase
  end

  mcfl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .pop_i      (pop),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data)
  );

  mcfl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking bench for the mhd cfl time step block
// streams random and directed cells with apb register phases, predicts each sweep result
// depends on mcfl_pkg and mhd_cfl_time_step
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import mcfl_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 1000;
  localparam logic [63:0] AllOnes32 = 64'h0000_0000_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  cell_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  result_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor copy of registers and sweep state
  logic [63:0] gamma_q = GammaReset;
  logic [63:0] dx_q = WidthReset;
  logic [63:0] eps_q = OffsetReset;
  logic [63:0] cfl_q = CourantReset;
  logic [63:0] min_step = AllOnes32;
  bit          any_bad = 1'b0;

  result_t step_results[$];
  int unsigned fails = 0;
  int unsigned quiet_cycles = 0;
  bit idle_on = 1'b1;

  mhd_cfl_time_step dut (.*);

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag(logic signed [31:0] v);
    longint s;
    s = longint'(v);
    return s < 0 ? -s : s;
  endfunction

  function automatic logic [63:0] capv(logic [63:0] x, logic [63:0] c);
    return x > c ? c : x;
  endfunction

  // fold one cell into the sweep minimum, return 1 with a step on a last cell
  function automatic bit fold_cell(cell_t c, output result_t r);
    longint rho, e;
    logic [63:0] ru, ax, ay, az, bx, by, bz, ux, kin, b2, loss, internal, gm1, p, s2;
    logic [63:0] speed, dx, den, cand;
    bit bad;
    rho = longint'(c.density);
    e = longint'(c.total_energy);
    bad = 1'b0;
    speed = 0;
    r = '0;
    if (rho <= 0) begin
      bad = 1'b1;
    end else begin
      ru = rho;
      ax = mag(c.momentum_x);
      ay = mag(c.momentum_y);
      az = mag(c.momentum_z);
      bx = mag(c.field_x);
      by = mag(c.field_y);
      bz = mag(c.field_z);
      ux = (ax << 16) / ru;
      kin = (ax * ax + ay * ay + az * az) / (2 * ru);
      b2 = bx * bx + by * by + bz * bz;
      loss = kin + (b2 >> 17);
      internal = 0;
      if (e < 0) bad = 1'b1;
      else if (loss > e) bad = 1'b1;
      else internal = e - loss;
      gm1 = gamma_q > OneQ16 ? gamma_q - OneQ16 : 0;
      p = (gm1 * internal) >> 16;
      s2 = capv(capv((gamma_q * p) / ru, SqCap) + capv(b2 / ru, SqCap), SqCap);
      speed = capv(ux + root64(s2 << 16), SpeedCap);
    end
    dx = dx_q != 0 ? dx_q : 1;
    den = ((speed << 16) / dx) + eps_q;
    cand = den == 0 ? AllOnes32 : capv((64'd1 << 40) / den, AllOnes32);
    if (cand < min_step) min_step = cand;
    if (bad) any_bad = 1'b1;
    if (!c.last_cell) return 1'b0;
    r.time_step = capv((min_step * cfl_q) >> 16, AllOnes32);
    r.bad_cell = any_bad;
    min_step = AllOnes32;
    any_bad = 1'b0;
    return 1'b1;
  endfunction

  // send one cell beat, with an optional idle burst first
  task automatic send_cell(cell_t c);
    result_t r;
    int unsigned gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = c;
    do @(posedge clk_i); while (in_stall_o);
    if (fold_cell(c, r)) step_results.push_back(r);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = AddrWidth'({idx, 2'b00});
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      RegGamma:   gamma_q = val & 32'h3FFFF;
      RegWidth:   dx_q = val & 32'h7FFF_FFFF;
      RegOffset:  eps_q = val & 32'hFFFF;
      RegCourant: cfl_q = val & 32'h1FFFF;
      default: ;
    endcase
  endtask

  // wait for every pending step, then let the back settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (step_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] g, logic [31:0] w, logic [31:0] o, logic [31:0] k);
    write_reg(RegGamma, g);
    write_reg(RegWidth, w);
    write_reg(RegOffset, o);
    write_reg(RegCourant, k);
  endtask

  function automatic cell_t plain_cell(bit last);
    cell_t c;
    c.density = $urandom_range(32'h1000, 32'h40_0000);
    c.momentum_x = $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
    c.momentum_y = $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
    c.momentum_z = $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
    c.field_x = $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
    c.field_y = $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
    c.field_z = $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
    c.total_energy = $urandom_range(0, 32'h4000_0000);
    c.last_cell = last;
    return c;
  endfunction

  function automatic cell_t noise_cell(bit last);
    cell_t c;
    c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, last};
    return c;
  endfunction

  function automatic cell_t filled(logic [31:0] v, bit last);
    cell_t c;
    c = {v, v, v, v, v, v, v, v, last};
    return c;
  endfunction

  // extremes and each special case, under default registers
  task automatic test_directed();
    cell_t c;
    send_cell(filled(32'h7FFF_FFFF, 1'b1));
    send_cell(filled(32'h8000_0000, 1'b1));
    send_cell(filled(32'h0, 1'b1));
    send_cell(filled(32'hFFFF_FFFF, 1'b1));
    // negative energy with good density
    c = plain_cell(1'b1);
    c.total_energy = 32'sh8000_0000;
    send_cell(c);
    // energy below kinetic plus magnetic loss
    c = plain_cell(1'b0);
    c.density = 32'h1_0000;
    c.momentum_x = 32'sh7FFF_FFFF;
    c.total_energy = 32'h10;
    send_cell(c);
    send_cell(plain_cell(1'b1));
    // a calm multi cell sweep
    for (int i = 0; i < 4; i++) send_cell(plain_cell(i == 3));
    drain();
  endtask

  // register extremes: gamma below one, zero width, zero eps, courant above one
  task automatic test_register_extremes();
    cell_t c;
    set_regs(32'h0, 32'h0, 32'h0, 32'h1FFFF);
    c = filled(32'h0, 1'b0);
    c.density = 32'h1_0000;
    send_cell(c);
    c.last_cell = 1'b1;
    send_cell(c);
    send_cell(plain_cell(1'b1));
    send_cell(filled(32'h7FFF_FFFF, 1'b1));
    drain();
    set_regs(32'h3_0000, 32'h7FFF_FFFF, 32'hFFFF, 32'h0);
    send_cell(plain_cell(1'b1));
    send_cell(filled(32'h7FFF_FFFF, 1'b1));
    drain();
    set_regs(32'h1_0000, 32'h1, 32'h1, 32'h1_0000);
    send_cell(plain_cell(1'b1));
    send_cell(noise_cell(1'b1));
    drain();
  endtask

  // random sweeps with register changes between chunks
  task automatic test_random_sweeps(int unsigned total, int unsigned chunk);
    bit last;
    for (int unsigned n = 0; n < total; n++) begin
      last = ($urandom_range(0, 4) == 0) || ((n % chunk) == chunk - 1);
      if ($urandom_range(0, 9) == 0) send_cell(noise_cell(last));
      else send_cell(plain_cell(last));
      if ((n % chunk) == chunk - 1) begin
        drain();
        set_regs($urandom_range(32'h1_0000, 32'h3_0000), $urandom_range(1, 32'h10_0000),
                 $urandom_range(0, 32'hFFFF), $urandom_range(0, 32'h1_0000));
      end
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_sweeps(300, 300);
  endtask

  // result side stall bursts
  initial begin
    int unsigned left;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        if (idle_on && $urandom_range(0, 3) == 0) begin
          out_stall_i = 1'b1;
          left = $urandom_range(1, 14);
        end else begin
          out_stall_i = 1'b0;
          left = $urandom_range(1, 20);
        end
      end else begin
        left--;
      end
    end
  end

  // compare each result beat with the oldest predicted step
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (step_results.size() == 0) begin
        $error("unexpected result beat time_step=%h bad_cell=%b",
               out_data_o.time_step, out_data_o.bad_cell);
        fails++;
      end else begin
        want = step_results.pop_front();
        if (out_data_o.time_step !== want.time_step) begin
          $error("time_step expected %h actual %h", want.time_step, out_data_o.time_step);
          fails++;
        end
        if (out_data_o.bad_cell !== want.bad_cell) begin
          $error("bad_cell expected %b actual %b", want.bad_cell, out_data_o.bad_cell);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("[mhd_cfl_time_step] ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_register_extremes();
    test_random_sweeps(1400, 350);
    test_back_to_back();
    drain();
    if (step_results.size() != 0) begin
      $error("%0d predicted steps never arrived", step_results.size());
      fails++;
    end
    if (fails == 0) begin
      $display("[mhd_cfl_time_step] OK");
    end else begin
      $display("[mhd_cfl_time_step] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
